[hdl/jpeg_coefficient_run_decoder_assert.svh]
// Assertion macros shared by the coefficient decoder RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef JPEG_COEFFICIENT_RUN_DECODER_ASSERT_SVH
`define JPEG_COEFFICIENT_RUN_DECODER_ASSERT_SVH

`ifndef SYNTH

// The consequence must hold in the same cycle as the condition.
`define JCRD_ASSERT_SAME(lbl, clk_s, rstn_s, cond, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (cons)) \
    else $error("jcrd assertion failed");

// The consequence must hold in the cycle after the condition.
`define JCRD_ASSERT_NEXT(lbl, clk_s, rstn_s, cond, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (cons)) \
    else $error("jcrd assertion failed");

`else

`define JCRD_ASSERT_SAME(lbl, clk_s, rstn_s, cond, cons)
`define JCRD_ASSERT_NEXT(lbl, clk_s, rstn_s, cond, cons)

`endif

`endif

[hdl/jcrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jcrd_pkg;

  // Coefficients in one 8x8 block.
  localparam int unsigned BLOCK_COEFFS = 64;

  // Request type codes. Code 3 is unused and is dropped.
  typedef enum logic [1:0] {
    REQ_QUANT_LOAD = 2'd0,
    REQ_DC         = 2'd1,
    REQ_AC         = 2'd2
  } req_type_t;

  // One input request from the entropy decoder.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  component;
    logic [1:0]  table_sel;
    logic [3:0]  zero_run;
    logic [3:0]  coeff_size;
    logic [15:0] extra_bits;
    logic [5:0]  quant_index;
    logic [7:0]  quant_value;
  } in_item_t;

  // One decoded coefficient.
  typedef struct packed {
    logic [5:0]         position;
    logic signed [15:0] coeff_value;
    logic               has_value;
    logic               block_last;
    logic               overrun;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/jcrd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel into the decoder.
interface jcrd_in_if;
  import jcrd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

[hdl/jcrd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Coefficient channel out of the decoder.
interface jcrd_out_if;
  import jcrd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

[hdl/jcrd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module jcrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/jpeg_coefficient_run_decoder.sv]
// JPEG baseline coefficient decoder, placed after the Huffman decoder.
// in_ch carries one request per handshake: a quantization load, a DC symbol
// or an AC symbol. out_ch carries one coefficient with its zigzag position,
// or an end-of-block or overrun marker with has_value low and block_last high.
// Loads and unused request codes produce no output.
// Throughput is one request per cycle while in_ch.ready is high. A request
// that produces a result has its quantization step read from the store RAM
// at the edge that accepts it. When the first stage advances, the value is
// multiplied by the step, saturated and loaded into the output register.
// After reset the DC predictors are zero and AC placement starts at position
// zero. The quantization store is not cleared; every entry must be loaded
// before a symbol reads it.
// When out_ch stalls, the output register and the stage behind it hold, and
// in_ch.ready drops only once both are full. Loads and unused codes then wait
// like any other request.
`timescale 1ns / 1ps
`default_nettype none
`include "jpeg_coefficient_run_decoder_assert.svh"

module jpeg_coefficient_run_decoder #(
  parameter int unsigned QUANT_TABLES = 4,
  parameter int unsigned COMPONENTS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  jcrd_in_if.sink     in_ch,
  jcrd_out_if.source  out_ch
);

  import jcrd_pkg::*;

  localparam int unsigned CompW      = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int unsigned StoreDepth = QUANT_TABLES * BLOCK_COEFFS;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam logic [6:0]  NoBlock    = 7'(BLOCK_COEFFS);
  localparam logic [5:0]  LastPos    = 6'(BLOCK_COEFFS - 1);

  // Stage between the store read and the multiply.
  typedef struct packed {
    logic [5:0]         position;
    logic signed [15:0] value;
    logic               has_value;
    logic               block_last;
    logic               overrun;
  } stage_t;

  // Reduces a 2-bit selector modulo a small constant by repeated subtraction.
  function automatic logic [1:0] reduce_sel(input logic [1:0] v, input int unsigned m);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= m) begin
        r = r - 2'(m);
      end
    end
    return r;
  endfunction

  // Turns a size category and its raw bits into a signed value.
  function automatic logic signed [15:0] size_to_value(input logic [3:0] sz,
                                                       input logic [15:0] raw);
    logic [15:0] mask;
    logic [15:0] mag;
    mask = 16'((17'd1 << sz) - 17'd1);
    mag  = raw & mask;
    if (sz == 4'd0) begin
      return 16'sd0;
    end else if (mag[4'(sz - 4'd1)]) begin
      return signed'(mag);
    end else begin
      return signed'(16'(mag - mask));
    end
  endfunction

  logic              in_accept;
  logic              s1_adv;
  logic              is_load;
  logic              is_dc;
  logic              is_ac;
  logic [1:0]        tbl_m;
  logic [CompW-1:0]  comp_idx;
  logic signed [15:0] sym_value;
  logic [15:0]       pred_sum;
  logic [6:0]        ac_pos;
  logic              ac_eob;
  logic              ac_ovr;
  logic              ac_last;
  logic [5:0]        rd_pos;
  logic [StoreAw-1:0] rd_addr;
  logic [StoreAw-1:0] wr_addr;
  logic [7:0]        q_step;
  stage_t            s1_nxt;

  logic [6:0]        next_pos_r;
  logic [6:0]        next_pos_nxt;
  logic [15:0]       pred_r [COMPONENTS];
  logic              s1_valid_r;
  stage_t            s1_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic signed [24:0] product;
  logic signed [15:0] coeff_sat;

  // Handshake: the first stage moves on when the output register frees up.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept = in_ch.valid && in_ch.ready;

  // Request decode.
  always_comb begin
    is_load = 1'b0;
    is_dc   = 1'b0;
    is_ac   = 1'b0;
    case (in_ch.item.req_type)
      REQ_QUANT_LOAD: is_load = 1'b1;
      REQ_DC:         is_dc   = 1'b1;
      REQ_AC:         is_ac   = 1'b1;
      default: begin
      end
    endcase
  end

  assign tbl_m     = reduce_sel(in_ch.item.table_sel, QUANT_TABLES);
  assign comp_idx  = CompW'(reduce_sel(in_ch.item.component, COMPONENTS));
  assign sym_value = size_to_value(in_ch.item.coeff_size, in_ch.item.extra_bits);
  assign pred_sum  = pred_r[comp_idx] + 16'(sym_value);

  // AC placement: skip the run and check for end of block or overrun.
  assign ac_pos  = next_pos_r + {3'b000, in_ch.item.zero_run};
  assign ac_eob  = (in_ch.item.zero_run == 4'd0) && (in_ch.item.coeff_size == 4'd0);
  assign ac_ovr  = !ac_eob && ac_pos[6];
  assign ac_last = !ac_eob && !ac_ovr && (ac_pos[5:0] == LastPos);

  // Store addresses: table number above the zigzag position.
  assign rd_pos  = is_dc ? 6'd0 : ac_pos[5:0];
  assign rd_addr = StoreAw'({tbl_m, rd_pos});
  assign wr_addr = StoreAw'({tbl_m, in_ch.item.quant_index});

  // Contents of the first stage for a DC or AC request.
  always_comb begin
    s1_nxt            = '0;
    if (is_dc) begin
      s1_nxt.value     = signed'(pred_sum);
      s1_nxt.has_value = 1'b1;
    end else if (ac_eob || ac_ovr) begin
      s1_nxt.block_last = 1'b1;
      s1_nxt.overrun    = ac_ovr;
    end else begin
      s1_nxt.position   = ac_pos[5:0];
      s1_nxt.value      = sym_value;
      s1_nxt.has_value  = 1'b1;
      s1_nxt.block_last = ac_last;
    end
  end

  // Next placement position.
  always_comb begin
    next_pos_nxt = next_pos_r;
    if (in_accept && is_dc) begin
      next_pos_nxt = 7'd1;
    end else if (in_accept && is_ac) begin
      if (ac_eob || ac_ovr || ac_last) begin
        next_pos_nxt = NoBlock;
      end else begin
        next_pos_nxt = ac_pos + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pos_r <= '0;
    end else begin
      next_pos_r <= next_pos_nxt;
    end
  end

  // DC predictors, one per component.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COMPONENTS; i++) begin
        pred_r[i] <= '0;
      end
    end else if (in_accept && is_dc) begin
      pred_r[comp_idx] <= pred_sum;
    end
  end

  // Quantization store.
  jcrd_ram #(
    .WIDTH (8),
    .DEPTH (StoreDepth)
  ) u_quant_ram (
    .clk   (clk),
    .we    (in_accept && is_load),
    .waddr (wr_addr),
    .wdata (in_ch.item.quant_value),
    .re    (in_accept && (is_dc || is_ac)),
    .raddr (rd_addr),
    .rdata (q_step)
  );

  // First stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept && (is_dc || is_ac)) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (is_dc || is_ac)) begin
      s1_r <= s1_nxt;
    end
  end

  // Dequantize and saturate to 16 bits.
  assign product = 25'(s1_r.value) * signed'({1'b0, q_step});

  always_comb begin
    if (product > 25'sd32767) begin
      coeff_sat = 16'sh7FFF;
    end else if (product < -25'sd32768) begin
      coeff_sat = 16'sh8000;
    end else begin
      coeff_sat = 16'(product);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r.position    <= s1_r.position;
      out_r.coeff_value <= s1_r.has_value ? coeff_sat : 16'sd0;
      out_r.has_value   <= s1_r.has_value;
      out_r.block_last  <= s1_r.block_last;
      out_r.overrun     <= s1_r.overrun;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_r;

  // Checks on placement state and result markers.
  `JCRD_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, next_pos_r <= NoBlock)
  `JCRD_ASSERT_NEXT(a_dc_opens_block, clk, rst_n, in_accept && is_dc, next_pos_r == 7'd1)
  `JCRD_ASSERT_SAME(a_overrun_marker, clk, rst_n, out_valid_r && out_r.overrun, out_r.block_last && !out_r.has_value)
  `JCRD_ASSERT_SAME(a_last_pos_ends, clk, rst_n, out_valid_r && out_r.has_value && (out_r.position == LastPos), out_r.block_last)

endmodule

`default_nettype wire
